FILE: hdl/header_checksum_frame_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the header/checksum frame receiver checks
// ----------------------------------------------------------------------------
`ifndef HEADER_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH
`define HEADER_CHECKSUM_FRAME_RECEIVER_TOP_MACROS_SVH

// Property checked at every rising edge, masked while reset is held
`define HCFR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included
`define HCFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hcfr_pkg.sv
// ----------------------------------------------------------------------------
// hcfr_pkg
// Shared types and frame constants for the header/checksum frame receiver.
// ----------------------------------------------------------------------------
package hcfr_pkg;

  // Number of payload bytes presented on the result channel
  localparam int OUT_FIELDS = 6;

  typedef logic [7:0] byte_t;

  // Frame marks
  localparam byte_t HEADER_FIRST  = 8'hFA;
  localparam byte_t HEADER_SECOND = 8'hAF;
  localparam byte_t TRAILER_MARK  = 8'hED;

  // One result item from the parser to the output register
  typedef struct packed {
    logic                     valid;
    byte_t [OUT_FIELDS-1:0]   payload;
  } result_t;

endpackage

FILE: hdl/hcfr_in_reg.sv
// ----------------------------------------------------------------------------
// hcfr_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module hcfr_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  hcfr_pkg::byte_t in_rx_byte,
  output logic            in_stall,
  input  logic            advance,
  output logic            byte_valid,
  output hcfr_pkg::byte_t byte_data
);

  logic            valid_r;
  logic            valid_nxt;
  hcfr_pkg::byte_t data_r;
  hcfr_pkg::byte_t data_nxt;
  logic            load;

  // Register is free when empty or when its item moves on this cycle
  assign load     = !valid_r || advance;
  assign in_stall = valid_r && !advance;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        data_nxt = in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

FILE: hdl/hcfr_parser.sv
// ----------------------------------------------------------------------------
// hcfr_parser
// Frame state: header hunt, payload capture, running sum, checksum and
// trailer check. Produces the result for the byte it consumes.
// ----------------------------------------------------------------------------
module hcfr_parser #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  hcfr_pkg::byte_t   byte_data,
  input  logic              advance,
  output hcfr_pkg::result_t result
);

  localparam int POS_W = $clog2(PAYLOAD_BYTES + 3);
  localparam logic [POS_W-1:0] POS_HUNT     = '0;
  localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST_PAY = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(PAYLOAD_BYTES + 1);

  hcfr_pkg::byte_t  prev_byte_r, prev_byte_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  hcfr_pkg::byte_t  sum_r, sum_nxt;
  hcfr_pkg::byte_t  chk_r, chk_nxt;
  hcfr_pkg::byte_t  store_r   [PAYLOAD_BYTES];
  hcfr_pkg::byte_t  store_nxt [PAYLOAD_BYTES];
  hcfr_pkg::byte_t  pay_w     [hcfr_pkg::OUT_FIELDS];
  logic             step;
  logic             produce;
  logic             in_payload;

  assign step       = byte_valid && advance;
  assign in_payload = (pos_r != POS_HUNT) && (pos_r <= POS_LAST_PAY);

  // Position, sum and checksum update
  always_comb begin
    prev_byte_nxt = prev_byte_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    chk_nxt       = chk_r;
    produce       = 1'b0;
    if (step) begin
      prev_byte_nxt = byte_data;
      if (pos_r == POS_HUNT) begin
        if (prev_byte_r == hcfr_pkg::HEADER_FIRST &&
            byte_data == hcfr_pkg::HEADER_SECOND) begin
          pos_nxt = POS_FIRST;
          sum_nxt = '0;
        end
      end else if (in_payload) begin
        sum_nxt = sum_r + byte_data;
        pos_nxt = pos_r + POS_W'(1);
      end else if (pos_r == POS_CHECKSUM) begin
        chk_nxt = byte_data;
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        // trailer byte: frame done, good or bad
        produce = (chk_r == sum_r) && (byte_data == hcfr_pkg::TRAILER_MARK);
        pos_nxt = POS_HUNT;
        sum_nxt = '0;
      end
    end
  end

  // Payload capture, one slot per position
  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      store_nxt[i] = store_r[i];
      if (step && pos_r == POS_W'(i + 1)) begin
        store_nxt[i] = byte_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= '0;
      pos_r       <= POS_HUNT;
      sum_r       <= '0;
    end else begin
      prev_byte_r <= prev_byte_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    store_r <= store_nxt;
  end

  // Output fields beyond the payload length read as zero
  for (genvar j = 0; j < hcfr_pkg::OUT_FIELDS; j++) begin : g_pay
    if (j < PAYLOAD_BYTES) begin : g_used
      assign pay_w[j] = store_r[j];
    end else begin : g_zero
      assign pay_w[j] = '0;
    end
  end

  always_comb begin
    result.valid = produce;
    for (int k = 0; k < hcfr_pkg::OUT_FIELDS; k++) begin
      result.payload[k] = pay_w[k];
    end
  end

endmodule

FILE: hdl/hcfr_out_reg.sv
// ----------------------------------------------------------------------------
// hcfr_out_reg
// Result register: holds a finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module hcfr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  hcfr_pkg::result_t result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_stall,
  output hcfr_pkg::byte_t   out_payload_0,
  output hcfr_pkg::byte_t   out_payload_1,
  output hcfr_pkg::byte_t   out_payload_2,
  output hcfr_pkg::byte_t   out_payload_3,
  output hcfr_pkg::byte_t   out_payload_4,
  output hcfr_pkg::byte_t   out_payload_5
);

  logic                                       valid_r, valid_nxt;
  hcfr_pkg::byte_t [hcfr_pkg::OUT_FIELDS-1:0] pay_r, pay_nxt;

  // Register takes a new item when empty or when its item leaves now
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    pay_nxt   = pay_r;
    if (advance) begin
      valid_nxt = result.valid;
      if (result.valid) begin
        pay_nxt = result.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
  end

  assign out_valid     = valid_r;
  assign out_payload_0 = pay_r[0];
  assign out_payload_1 = pay_r[1];
  assign out_payload_2 = pay_r[2];
  assign out_payload_3 = pay_r[3];
  assign out_payload_4 = pay_r[4];
  assign out_payload_5 = pay_r[5];

endmodule

FILE: hdl/header_checksum_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// header_checksum_frame_receiver_top
// Serial frame receiver: header 0xFA 0xAF, payload, sum checksum, trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one received
//   byte per item. The block hunts for 0xFA followed by 0xAF, collects
//   PAYLOAD_BYTES payload bytes, a checksum byte (8-bit wrapping sum of the
//   payload) and a trailer byte 0xED. A good frame gives one item on the
//   result channel (out_valid / out_stall / out_payload_0..5); a bad frame
//   gives nothing and hunting restarts.
//   Throughput: one byte per cycle while no result waits under out_stall;
//   the parser step between the input and result registers is combinational.
//   Result is registered; it appears the cycle after the trailer is taken.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to hunting with the previous byte cleared.
//   When the receiver holds out_stall with a result pending, that result
//   stays put, one more byte is buffered in the input register, and then
//   in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module header_checksum_frame_receiver_top #(
  parameter int PAYLOAD_BYTES = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hcfr_pkg::byte_t in_rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output hcfr_pkg::byte_t out_payload_0,
  output hcfr_pkg::byte_t out_payload_1,
  output hcfr_pkg::byte_t out_payload_2,
  output hcfr_pkg::byte_t out_payload_3,
  output hcfr_pkg::byte_t out_payload_4,
  output hcfr_pkg::byte_t out_payload_5
);

  logic              advance;
  logic              byte_valid;
  hcfr_pkg::byte_t   byte_data;
  hcfr_pkg::result_t result;

  // Input register
  hcfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Frame parser
  hcfr_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .advance    (advance),
    .result     (result)
  );

  // Result register
  hcfr_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .result        (result),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_payload_0 (out_payload_0),
    .out_payload_1 (out_payload_1),
    .out_payload_2 (out_payload_2),
    .out_payload_3 (out_payload_3),
    .out_payload_4 (out_payload_4),
    .out_payload_5 (out_payload_5)
  );

endmodule

FILE: hdl/hcfr_checker.sv
// ----------------------------------------------------------------------------
// hcfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "header_checksum_frame_receiver_top_macros.svh"

module hcfr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input hcfr_pkg::byte_t in_rx_byte,
  input logic            out_valid,
  input logic            out_stall,
  input hcfr_pkg::byte_t out_payload_0,
  input hcfr_pkg::byte_t out_payload_1,
  input hcfr_pkg::byte_t out_payload_2,
  input hcfr_pkg::byte_t out_payload_3,
  input hcfr_pkg::byte_t out_payload_4,
  input hcfr_pkg::byte_t out_payload_5
);

  // Reset empties the result register
  `HCFR_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Input backs up only behind a stalled result
  `HCFR_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "in_stall without a stalled result")

  // Results never come back to back: a taken result leaves the register empty
  `HCFR_ASSERT(a_result_gap, clk, rst_n, (out_valid && !out_stall) |=> !out_valid, "results too close together")

  // A stalled result holds
  `HCFR_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_payload_0) && $stable(out_payload_1) && $stable(out_payload_2) && $stable(out_payload_3) && $stable(out_payload_4) && $stable(out_payload_5)), "stalled result changed")

  // A stalled input item holds
  `HCFR_ASSERT(a_in_hold, clk, rst_n, (in_valid && in_stall) |=> (in_valid && $stable(in_rx_byte)), "stalled input changed")

endmodule

bind header_checksum_frame_receiver_top hcfr_checker u_hcfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_rx_byte    (in_rx_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_payload_0 (out_payload_0),
  .out_payload_1 (out_payload_1),
  .out_payload_2 (out_payload_2),
  .out_payload_3 (out_payload_3),
  .out_payload_4 (out_payload_4),
  .out_payload_5 (out_payload_5)
);
